FILE: sv/srrip_pkg.sv
`timescale 1ns / 1ps
package srrip_pkg;
    localparam int unsigned CMD_W   = 1;
    localparam int unsigned SET_W   = 11;
    localparam int unsigned WAY_W   = 4;
    localparam int unsigned PC_W    = 14;
    localparam int unsigned ADDR_W  = 16;
    localparam int unsigned RUN_W   = 3;
    localparam int unsigned RRPV_W  = 2;
    localparam int unsigned CTR_W   = 2;

    localparam logic [CMD_W-1:0] CMD_VICTIM = 1'b0;
    localparam logic [CMD_W-1:0] CMD_UPDATE = 1'b1;

    localparam logic [RRPV_W-1:0] RRPV_NEAR    = 2'd0;
    localparam logic [RRPV_W-1:0] RRPV_LONG    = 2'd2;
    localparam logic [RRPV_W-1:0] RRPV_DISTANT = 2'd3;
    localparam logic [CTR_W-1:0]  CTR_MAX      = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [SET_W-1:0]  set_index;
        logic [WAY_W-1:0]  way_index;
        logic [PC_W-1:0]   pc_low;
        logic [ADDR_W-1:0] addr_lsbs;
        logic              was_hit;
    } t_req;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_DECAY
    } t_state;
endpackage

FILE: sv/srrip_if.sv
`timescale 1ns / 1ps
interface srrip_req_if;
    logic                                 valid;
    logic                                 ready;
    logic [srrip_pkg::CMD_W-1:0]          command;
    logic [srrip_pkg::SET_W-1:0]          set_index;
    logic [srrip_pkg::WAY_W-1:0]          way_index;
    logic [srrip_pkg::PC_W-1:0]           pc_low;
    logic [srrip_pkg::ADDR_W-1:0]         addr_lsbs;
    logic                                 was_hit;
    modport source (output valid, command, set_index, way_index, pc_low, addr_lsbs, was_hit,
                    input ready);
    modport sink   (input valid, command, set_index, way_index, pc_low, addr_lsbs, was_hit,
                    output ready);
endinterface

interface srrip_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [srrip_pkg::WAY_W-1:0] victim_way;
    modport source (output valid, victim_way, input ready);
    modport sink   (input valid, victim_way, output ready);
endinterface

FILE: sv/srrip_front.sv
`timescale 1ns / 1ps
// two-entry word queue between port and engine
module srrip_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    srrip_req_if.sink          i_req,
    output logic               o_valid,
    output srrip_pkg::t_req    o_req,
    input  logic               i_pop
);
    srrip_pkg::t_req r_q [2];
    logic            r_wp;
    logic            r_rp;
    logic [1:0]      r_cnt;
    logic            w_push;
    logic            w_pop;

    assign i_req.ready = (r_cnt != 2'd2);
    assign w_push      = i_req.valid && i_req.ready;
    assign o_valid     = (r_cnt != 2'd0);
    assign w_pop       = i_pop && o_valid;
    assign o_req       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= '{command: i_req.command, set_index: i_req.set_index,
                          way_index: i_req.way_index, pc_low: i_req.pc_low,
                          addr_lsbs: i_req.addr_lsbs, was_hit: i_req.was_hit};
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule

FILE: sv/srrip_back.sv
`timescale 1ns / 1ps
module srrip_back #(
    parameter int unsigned NUM_SETS          = 2048,
    parameter int unsigned NUM_WAYS          = 16,
    parameter int unsigned SIGNATURE_BITS    = 12,
    parameter int unsigned STREAM_LENGTH     = 4,
    parameter int unsigned DECAY_PERIOD_BITS = 12
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  srrip_pkg::t_req i_req,
    output logic            o_pop,
    srrip_rsp_if.source     o_rsp
);
    localparam int unsigned SI_W   = $clog2(NUM_SETS);
    localparam int unsigned WI_W   = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int unsigned SIG_N  = 1 << SIGNATURE_BITS;
    localparam int unsigned RV_W   = 2 * NUM_WAYS;
    localparam int unsigned CLR_N  = (NUM_SETS > SIG_N) ? NUM_SETS : SIG_N;
    localparam int unsigned CLR_W  = $clog2(CLR_N) + 1;
    localparam int unsigned SP_W   = (SIGNATURE_BITS + 2 > srrip_pkg::PC_W) ?
                                     srrip_pkg::PC_W - 2 : SIGNATURE_BITS;
    localparam int unsigned WBIG_W = ((WI_W > srrip_pkg::WAY_W) ? WI_W : srrip_pkg::WAY_W) + 1;

    logic [RV_W-1:0]                r_rrpv  [NUM_SETS];
    logic [NUM_WAYS-1:0]            r_reuse [NUM_SETS];
    logic [srrip_pkg::ADDR_W-1:0]   r_laddr [NUM_SETS];
    logic [srrip_pkg::ADDR_W-1:0]   r_lstr  [NUM_SETS];
    logic [srrip_pkg::RUN_W-1:0]    r_run   [NUM_SETS];
    logic [srrip_pkg::CTR_W-1:0]    r_ctr   [SIG_N];

    srrip_pkg::t_state              r_state, n_state;
    logic [CLR_W-1:0]               r_clr, n_clr;
    logic                           r_reuse_only, n_reuse_only;
    logic [DECAY_PERIOD_BITS-1:0]   r_upd, n_upd;

    logic [RV_W-1:0]                r_rd_rrpv;
    logic [NUM_WAYS-1:0]            r_rd_reuse;
    logic [srrip_pkg::ADDR_W-1:0]   r_rd_laddr, r_rd_lstr;
    logic [srrip_pkg::RUN_W-1:0]    r_rd_run;
    logic [srrip_pkg::CTR_W-1:0]    r_rd_ctr;

    logic                           r_ovalid;
    logic [srrip_pkg::WAY_W-1:0]    r_oway;

    logic [SI_W-1:0]                w_set;
    logic [SIGNATURE_BITS-1:0]      w_sig;
    logic [WI_W-1:0]                w_way;
    logic                           w_way_ok;
    logic                           w_out_free;
    logic                           w_rd;
    logic                           w_exec;
    logic                           w_clr_wr;

    logic [srrip_pkg::ADDR_W-1:0]   w_stride;
    logic                           w_same;
    logic [srrip_pkg::RUN_W-1:0]    w_run;
    logic [srrip_pkg::ADDR_W-1:0]   w_lstr;
    logic                           w_streams;
    logic [srrip_pkg::RRPV_W-1:0]   w_ins;
    logic [srrip_pkg::CTR_W-1:0]    w_ctr;
    logic [RV_W-1:0]                w_rrpv;
    logic [NUM_WAYS-1:0]            w_reuse;
    logic [srrip_pkg::WAY_W-1:0]    w_victim;

    assign w_set    = SI_W'(i_req.set_index);
    assign w_sig    = SIGNATURE_BITS'(i_req.pc_low[SP_W+1:2]);
    assign w_way    = WI_W'(i_req.way_index);
    assign w_way_ok = WBIG_W'(i_req.way_index) < WBIG_W'(NUM_WAYS);
    assign w_out_free = !r_ovalid || o_rsp.ready;

    assign o_rsp.valid      = r_ovalid;
    assign o_rsp.victim_way = r_oway;

    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_reuse_only = r_reuse_only;
        n_upd        = r_upd;
        w_rd         = 1'b0;
        w_exec       = 1'b0;
        w_clr_wr     = 1'b0;
        o_pop        = 1'b0;
        case (r_state)
            srrip_pkg::ST_CLEAR, srrip_pkg::ST_DECAY: begin
                w_clr_wr = 1'b1;
                n_clr    = r_clr + CLR_W'(1);
                if (r_clr == CLR_W'(CLR_N - 1)) begin
                    n_state = srrip_pkg::ST_IDLE;
                end
            end
            srrip_pkg::ST_IDLE: begin
                if (i_valid) begin
                    w_rd    = 1'b1;
                    n_state = srrip_pkg::ST_EXEC;
                end
            end
            srrip_pkg::ST_EXEC: begin
                if (i_req.command == srrip_pkg::CMD_UPDATE || w_out_free) begin
                    w_exec  = 1'b1;
                    o_pop   = 1'b1;
                    n_state = srrip_pkg::ST_IDLE;
                    if (i_req.command == srrip_pkg::CMD_UPDATE) begin
                        n_upd = r_upd + DECAY_PERIOD_BITS'(1);
                        if (n_upd == '0) begin
                            n_state      = srrip_pkg::ST_DECAY;
                            n_clr        = CLR_W'(CLR_N - NUM_SETS);
                            n_reuse_only = 1'b1;
                        end
                    end
                end
            end
            default: n_state = srrip_pkg::ST_CLEAR;
        endcase
    end

    always_comb begin
        w_stride = i_req.addr_lsbs - r_rd_laddr;
        w_same   = (r_rd_run != '0) && (w_stride != '0) && (w_stride == r_rd_lstr);
        if (w_same) begin
            w_lstr = r_rd_lstr;
            w_run  = (r_rd_run < srrip_pkg::RUN_W'(STREAM_LENGTH)) ?
                     r_rd_run + srrip_pkg::RUN_W'(1) : r_rd_run;
        end else begin
            w_lstr = w_stride;
            w_run  = srrip_pkg::RUN_W'(1);
        end
        w_streams = w_same && (w_run >= srrip_pkg::RUN_W'(STREAM_LENGTH));

        if (w_streams)                 w_ins = srrip_pkg::RRPV_DISTANT;
        else if (r_rd_ctr >= 2'd2)     w_ins = srrip_pkg::RRPV_NEAR;
        else if (r_rd_ctr == 2'd1)     w_ins = srrip_pkg::RRPV_LONG;
        else                           w_ins = srrip_pkg::RRPV_DISTANT;

        w_rrpv  = r_rd_rrpv;
        w_reuse = r_rd_reuse;
        if (i_req.was_hit) begin
            w_ctr = (r_rd_ctr == srrip_pkg::CTR_MAX) ? r_rd_ctr : r_rd_ctr + 2'd1;
            if (w_way_ok) begin
                w_rrpv[2*w_way +: 2] = srrip_pkg::RRPV_NEAR;
                w_reuse[w_way]       = 1'b1;
            end
        end else begin
            w_ctr = (r_rd_ctr == '0) ? r_rd_ctr : r_rd_ctr - 2'd1;
            if (w_way_ok) begin
                w_rrpv[2*w_way +: 2] = w_ins;
                w_reuse[w_way]       = 1'b0;
            end
        end
    end

    always_comb begin
        w_victim = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            if (r_rd_rrpv[2*w +: 2] == srrip_pkg::RRPV_DISTANT) begin
                w_victim = srrip_pkg::WAY_W'(w);
            end
        end
        for (int l = 0; l < 4; l++) begin
            for (int w = NUM_WAYS - 1; w >= 0; w--) begin
                if (r_rd_rrpv[2*w +: 2] == 2'(l) && !r_rd_reuse[w]) begin
                    w_victim = srrip_pkg::WAY_W'(w);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd) begin
            r_rd_rrpv  <= r_rrpv[w_set];
            r_rd_reuse <= r_reuse[w_set];
            r_rd_laddr <= r_laddr[w_set];
            r_rd_lstr  <= r_lstr[w_set];
            r_rd_run   <= r_run[w_set];
            r_rd_ctr   <= r_ctr[w_sig];
        end
        if (w_clr_wr) begin
            if (r_clr >= CLR_W'(CLR_N - NUM_SETS)) begin
                r_reuse[SI_W'(r_clr - CLR_W'(CLR_N - NUM_SETS))] <= '0;
                if (!r_reuse_only) begin
                    r_rrpv[SI_W'(r_clr - CLR_W'(CLR_N - NUM_SETS))]  <= '1;
                    r_laddr[SI_W'(r_clr - CLR_W'(CLR_N - NUM_SETS))] <= '0;
                    r_lstr[SI_W'(r_clr - CLR_W'(CLR_N - NUM_SETS))]  <= '0;
                    r_run[SI_W'(r_clr - CLR_W'(CLR_N - NUM_SETS))]   <= '0;
                end
            end
            if (!r_reuse_only && r_clr >= CLR_W'(CLR_N - SIG_N)) begin
                r_ctr[SIGNATURE_BITS'(r_clr - CLR_W'(CLR_N - SIG_N))] <= '0;
            end
        end else if (w_exec && i_req.command == srrip_pkg::CMD_UPDATE) begin
            r_rrpv[w_set]  <= w_rrpv;
            r_reuse[w_set] <= w_reuse;
            r_laddr[w_set] <= i_req.addr_lsbs;
            r_lstr[w_set]  <= w_lstr;
            r_run[w_set]   <= w_run;
            r_ctr[w_sig]   <= w_ctr;
        end
        if (w_exec && i_req.command == srrip_pkg::CMD_VICTIM) begin
            r_oway <= w_victim;
        end
        if (!i_rst_n) begin
            r_state      <= srrip_pkg::ST_CLEAR;
            r_clr        <= '0;
            r_reuse_only <= 1'b0;
            r_upd        <= '0;
            r_ovalid     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr        <= n_clr;
            r_reuse_only <= n_reuse_only;
            r_upd        <= n_upd;
            if (w_exec && i_req.command == srrip_pkg::CMD_VICTIM) begin
                r_ovalid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end
endmodule

FILE: sv/ship_rrip_stream_replacement.sv
`timescale 1ns / 1ps
// Cache replacement engine (2-bit RRIP with PC outcome counters and per-set stream
// detection). One word at a time, the engine reads the set and signature memories,
// then picks a victim or writes the updated set back; a victim word waits while
// the previous response is not taken. A two-word queue sits in front. After reset, a
// pass clearing all sets and signature counters runs before any word is taken; every
// 2^DECAY_PERIOD_BITS updates the engine stalls for a pass that clears reuse flags.
module ship_rrip_stream_replacement #(
    parameter int unsigned NUM_SETS          = 2048,
    parameter int unsigned NUM_WAYS          = 16,
    parameter int unsigned SIGNATURE_BITS    = 12,
    parameter int unsigned STREAM_LENGTH     = 4,
    parameter int unsigned DECAY_PERIOD_BITS = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    srrip_req_if.sink   i_req,
    srrip_rsp_if.source o_rsp
);
    logic            w_valid;
    logic            w_pop;
    srrip_pkg::t_req w_req;

    srrip_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_valid (w_valid),
        .o_req   (w_req),
        .i_pop   (w_pop)
    );

    srrip_back #(
        .NUM_SETS          (NUM_SETS),
        .NUM_WAYS          (NUM_WAYS),
        .SIGNATURE_BITS    (SIGNATURE_BITS),
        .STREAM_LENGTH     (STREAM_LENGTH),
        .DECAY_PERIOD_BITS (DECAY_PERIOD_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid),
        .i_req   (w_req),
        .o_pop   (w_pop),
        .o_rsp   (o_rsp)
    );
endmodule
